// File: src/rc4v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4v_pkg
// Shared types and codes for the RC4-style stream cipher block.
// ----------------------------------------------------------------------------
package rc4v_pkg;

  typedef logic [7:0] byte_t;

  localparam logic KIND_REKEY = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Control from the sequencer to the permutation store
  typedef struct packed {
    logic  clr;      // forget all writes, entries read as identity from now on
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
    byte_t rd_addr;
  } perm_ctl_t;

endpackage

// File: src/rc4v_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4v_perm_ram
// 256 x 8 permutation store: one write and one registered read per cycle.
// Per-entry valid bits stand in for the reset and identity fills.
// ----------------------------------------------------------------------------
module rc4v_perm_ram
  import rc4v_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  perm_ctl_t ctl,
  output byte_t     rd_data
);

  byte_t        mem [256];
  logic [255:0] valid;
  logic         keyed;
  byte_t        rd_mem;
  logic         rd_valid;
  byte_t        rd_dflt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_mem <= mem[ctl.rd_addr];
  end

  // Unwritten entries read as zero before the first rekey, as their index after
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      keyed    <= 1'b0;
      rd_valid <= 1'b0;
      rd_dflt  <= '0;
    end else begin
      rd_valid <= valid[ctl.rd_addr];
      rd_dflt  <= keyed ? ctl.rd_addr : 8'h00;
      if (ctl.clr) begin
        valid <= '0;
        keyed <= 1'b1;
      end else if (ctl.wr_en) begin
        valid[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_mem : rd_dflt;

endmodule

// File: src/rc4_variant_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_variant_stream_cipher
// RC4-style cipher: 64-bit key register, per-packet position index.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   tdata[7:0] data_byte; tuser[0] kind, tuser[1] packet_start
// m_*      out  tdata[7:0] out_byte
// cfg_*    in   key_bytes write, no read-back
//
// A data item passes RDJ, SWI, SWJ and OUT to the output register, and the
// next item can be taken in the cycle after; the permutation store sees one
// registered read and at most one write per cycle. A rekey item runs RDK,
// RDS, WRK and WRS for each of the 256 entries: four store accesses per swap.
// No input is taken while an item is in progress; a stalled output holds the
// last step of the next data item. Reset zeroes key, j and table, sets i to 1.
// ----------------------------------------------------------------------------
module rc4_variant_stream_cipher
  import rc4v_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] data_byte
  input  logic [1:0]  s_tuser,      // [0] kind, [1] packet_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [7:0] out_byte
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_K_RDK = 4'd1;
  localparam logic [3:0] ST_K_RDS = 4'd2;
  localparam logic [3:0] ST_K_WRK = 4'd3;
  localparam logic [3:0] ST_K_WRS = 4'd4;
  localparam logic [3:0] ST_D_RDJ = 4'd5;
  localparam logic [3:0] ST_D_SWI = 4'd6;
  localparam logic [3:0] ST_D_SWJ = 4'd7;
  localparam logic [3:0] ST_D_OUT = 4'd8;

  logic [3:0]  state;
  logic [63:0] key;
  byte_t       acc;
  byte_t       pos;
  byte_t       k;
  byte_t       sum;
  byte_t       idx_i;
  byte_t       idx_j;
  byte_t       s_i;
  byte_t       s_j;
  byte_t       t_idx;
  byte_t       ks;
  byte_t       data;

  perm_ctl_t   ctl;
  byte_t       rdval;
  byte_t       add_b;
  byte_t       add_c;
  byte_t       add_y;
  byte_t       key_byte;
  logic        in_acc;
  logic        out_free;

  rc4v_perm_ram u_perm (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rdval)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign key_byte = key[{k[2:0], 3'b000} +: 8];

  // Shared byte adder: schedule sum, j update and keystream index
  always_comb begin
    add_b = s_i;
    add_c = 8'h00;
    unique case (state)
      ST_K_RDS: begin
        add_b = sum;
        add_c = key_byte;
      end
      ST_D_RDJ: add_b = acc;
      default:  add_b = s_i;
    endcase
    add_y = rdval + add_b + add_c;
  end

  always_comb begin
    ctl         = '0;
    ctl.rd_addr = k;
    unique case (state)
      ST_IDLE: begin
        ctl.clr     = in_acc && (s_tuser[0] == KIND_REKEY);
        ctl.rd_addr = s_tuser[1] ? 8'd1 : pos;
      end
      ST_K_RDK: ctl.rd_addr = k;
      ST_K_RDS: ctl.rd_addr = add_y;
      ST_K_WRK: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = k;
        ctl.wr_data = rdval;
      end
      ST_K_WRS: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = sum;
        ctl.wr_data = s_i;
      end
      ST_D_RDJ: ctl.rd_addr = add_y;
      ST_D_SWI: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = idx_i;
        ctl.wr_data = rdval;
        ctl.rd_addr = add_y;
      end
      ST_D_SWJ: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = idx_j;
        ctl.wr_data = s_i;
      end
      default: ctl.rd_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr_en) begin
      key <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc      <= '0;
      pos      <= 8'd1;
      k        <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // in the output step the case below owns m_tvalid
      if (m_tvalid && m_tready && state != ST_D_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            data  <= s_tdata;
            idx_i <= ctl.rd_addr;
            k     <= '0;
            sum   <= '0;
            state <= (s_tuser[0] == KIND_REKEY) ? ST_K_RDK : ST_D_RDJ;
          end
        end
        ST_K_RDK: state <= ST_K_RDS;
        ST_K_RDS: begin
          s_i   <= rdval;
          sum   <= add_y;
          state <= ST_K_WRK;
        end
        ST_K_WRK: state <= ST_K_WRS;
        ST_K_WRS: begin
          k <= k + 8'd1;
          if (k == 8'hFF) begin
            acc   <= '0;
            pos   <= 8'd1;
            state <= ST_IDLE;
          end else begin
            state <= ST_K_RDK;
          end
        end
        ST_D_RDJ: begin
          s_i   <= rdval;
          idx_j <= add_y;
          acc   <= add_y;
          state <= ST_D_SWI;
        end
        ST_D_SWI: begin
          s_j   <= rdval;
          t_idx <= add_y;
          state <= ST_D_SWJ;
        end
        ST_D_SWJ: begin
          // the read saw the table before the swap finished
          if (t_idx == idx_i) begin
            ks <= s_j;
          end else if (t_idx == idx_j) begin
            ks <= s_i;
          end else begin
            ks <= rdval;
          end
          state <= ST_D_OUT;
        end
        ST_D_OUT: begin
          if (out_free) begin
            m_tdata  <= data ^ ks;
            m_tvalid <= 1'b1;
            pos      <= idx_i + 8'd1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_data_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_D_RDJ |=> state == ST_D_SWI)
    else $error("data sequence broke after j read");

  a_rekey_start: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser[0] == KIND_REKEY |=> state == ST_K_RDK)
    else $error("rekey item did not start the schedule");

  a_rekey_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_K_WRS && k == 8'hFF |=> acc == 8'h00 && pos == 8'd1 && state == ST_IDLE)
    else $error("schedule end did not reset j and i");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_D_OUT)
    else $error("output item raised outside final data step");

endmodule

// File: bench/tb_rc4_variant_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_variant_stream_cipher
// Self-checking bench for the RC4-style cipher with per-packet position index.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the permutation, j, i and the key. It
// predicts every output byte when the input item is accepted. A short table
// of directed items comes first: data on the all-zero table after reset,
// rekeys with junk in the ignored fields, back-to-back rekeys, one-byte
// packets and data with no packet start after a rekey. Six key settings
// follow, among them all-ones and all-zeros. Each setting carries packets of
// random data, some long enough to wrap the position index. A few items are
// stray rekeys or misplaced packet starts. Both sides idle at random, with
// stretches of steady flow.
// ----------------------------------------------------------------------------
module tb_rc4_variant_stream_cipher;
  import rc4v_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int SETTLE_TICKS = 1100;  // longer than a full rekey

  typedef struct packed {
    logic  kind;
    byte_t data;
    logic  start;
    logic  known;   // expected byte typed in below
    byte_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;     // [7:0] data_byte
  logic [1:0]  s_tuser = 2'b00;     // [0] kind, [1] packet_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;             // [7:0] out_byte
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = 64'h0;

  // cipher state as the bench sees it
  byte_t       sbox [256];
  byte_t       acc_j;
  byte_t       pos_i;
  logic [63:0] key_reg;

  byte_t expected_out_q [$];
  bit    steady_flow = 1'b0;
  int    error_count = 0;
  int    n_data = 0, n_rekey = 0, n_packets = 0, n_long = 0, n_keys = 0, n_checked = 0;

  // after reset the table is all zero, so the keystream is zero too
  stim_row_t directed_rows [13] = '{
    '{KIND_DATA,  8'h00, 1'b1, 1'b1, 8'h00},
    '{KIND_DATA,  8'hFF, 1'b0, 1'b1, 8'hFF},
    '{KIND_DATA,  8'h5A, 1'b1, 1'b1, 8'h5A},
    '{KIND_REKEY, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{KIND_DATA,  8'h00, 1'b0, 1'b0, 8'h00},
    '{KIND_DATA,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{KIND_DATA,  8'h12, 1'b1, 1'b0, 8'h00},
    '{KIND_DATA,  8'hC3, 1'b0, 1'b0, 8'h00},
    '{KIND_REKEY, 8'h00, 1'b0, 1'b0, 8'h00},
    '{KIND_REKEY, 8'hA5, 1'b1, 1'b0, 8'h00},
    '{KIND_DATA,  8'h80, 1'b1, 1'b0, 8'h00},
    '{KIND_DATA,  8'h01, 1'b1, 1'b0, 8'h00},
    '{KIND_DATA,  8'h7F, 1'b0, 1'b0, 8'h00}
  };

  rc4_variant_stream_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void run_key_schedule();
    byte_t sum;
    byte_t t;
    for (int k = 0; k < 256; k++) sbox[byte_t'(k)] = byte_t'(k);
    sum = 8'h00;
    for (int k = 0; k < 256; k++) begin
      sum = sbox[byte_t'(k)] + sum + key_reg[8 * (k % 8) +: 8];
      t = sbox[byte_t'(k)];
      sbox[byte_t'(k)] = sbox[sum];
      sbox[sum] = t;
    end
    acc_j = 8'h00;
    pos_i = 8'h01;
  endfunction

  function automatic byte_t cipher_byte(input byte_t d, input logic start);
    byte_t i;
    byte_t t;
    byte_t ks_idx;
    if (start) pos_i = 8'h01;
    i = pos_i;
    acc_j = acc_j + sbox[i];
    t = sbox[i];
    sbox[i] = sbox[acc_j];
    sbox[acc_j] = t;
    ks_idx = sbox[i] + sbox[acc_j];
    pos_i = i + 8'h01;
    return d ^ sbox[ks_idx];
  endfunction

  function automatic int draw_wait();
    return steady_flow ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic send_item(input logic kind, input byte_t data, input logic start,
                           input logic known = 1'b0, input byte_t want = 8'h00);
    int    gap;
    byte_t got;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {start, kind};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_REKEY) begin
      run_key_schedule();
      n_rekey++;
    end else begin
      got = cipher_byte(data, start);
      expected_out_q.push_back(known ? want : got);
      n_data++;
    end
  endtask

  // a rekey leaves nothing in the queue, so wait out its run as well
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // output side: random back-pressure per item
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out_q.size() == 0) begin
        $error("out_byte: expected none, actual %02h", m_tdata);
        error_count++;
      end else begin
        want = expected_out_q.pop_front();
        n_checked++;
        if (m_tdata !== want) begin
          $error("out_byte: expected %02h, actual %02h", want, m_tdata);
          error_count++;
        end
      end
    end
  end

  initial begin
    int          len;
    int          phase_items;
    logic [63:0] k;
    logic        st;

    foreach (sbox[n]) sbox[n] = 8'h00;
    acc_j   = 8'h00;
    pos_i   = 8'h01;
    key_reg = 64'h0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].kind, directed_rows[r].data, directed_rows[r].start,
                directed_rows[r].known, directed_rows[r].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: k = '1;
        1: k = '0;
        3: k = 64'hAA55_AA55_00FF_FF00;
        default: k = {$urandom, $urandom};
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= k;
      key_reg = k;
      n_keys++;
      @(posedge clk);
      cfg_wr_en <= 1'b0;

      // one setting keeps the old table, so the new key only lands later
      if (p != 4)
        send_item(KIND_REKEY, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        steady_flow = ($urandom_range(0, 4) == 0);
        if ((p == 1 && phase_items == 0) || $urandom_range(0, 9) == 0)
          len = $urandom_range(256, 300);   // wraps the position index
        else
          len = $urandom_range(1, 24);
        if (len > 255) n_long++;
        n_packets++;
        for (int b = 0; b < len; b++) begin
          if ($urandom_range(0, 99) < 2) begin
            send_item(KIND_REKEY, byte_t'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            phase_items++;
          end
          // now and then a packet misses its start, or one turns up mid-packet
          st = (b == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
          send_item(KIND_DATA, byte_t'($urandom_range(0, 255)), st);
          phase_items++;
        end
      end
    end
    steady_flow = 1'b0;
    settle();

    $display("sent %0d data items in %0d packets (%0d longer than 255) and %0d rekeys",
             n_data, n_packets, n_long, n_rekey);
    $display("%0d key settings, %0d output bytes checked, %0d mismatches",
             n_keys, n_checked, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
